// ----- hdl/siv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// siv_pkg
// Types and constants shared by the script instruction validator.
// ----------------------------------------------------------------------------
package siv_pkg;

  localparam logic [7:0] OP_PUSH_LEN1    = 8'h4c;
  localparam logic [7:0] OP_PUSH_LEN2    = 8'h4d;
  localparam logic [7:0] OP_PUSH_LEN4    = 8'h4e;
  localparam logic [7:0] OP_LAST_PUSH    = 8'h60;
  localparam logic [7:0] OP_DATA_CARRIER = 8'h6a;
  localparam logic [7:0] OP_LAST_DEFINED = 8'hba;

  localparam logic [15:0] RESET_ELEMENT_LIMIT = 16'd520;
  localparam logic [31:0] RESET_SCRIPT_LIMIT  = 32'd10000;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCRIPT_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } siv_phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic well_formed;
    logic valid_opcodes;
    logic push_only;
    logic unspendable;
  } out_word_t;

endpackage
`default_nettype wire

// ----- hdl/siv_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// siv_parse
// Per-script parse state; advances one input word per step and forms the
// four result flags for the word that ends a script.
// ----------------------------------------------------------------------------
module siv_parse
  import siv_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire in_word_t    in_i,
  input  wire logic [15:0] elem_limit_i,
  input  wire logic [31:0] script_limit_i,
  output      out_word_t   res_o
);

  siv_phase_e  phase_q, phase_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [1:0]  len_idx_q, len_idx_d;
  logic [31:0] pay_left_q, pay_left_d;
  logic [31:0] cnt_q, cnt_d;
  logic        bad_q, bad_d;
  logic        nonpush_q, nonpush_d;
  logic        ret_q, ret_d;

  logic [7:0]  b;
  logic [31:0] pay_or;
  logic        over;
  logic        well;

  assign b      = in_i.data_byte;
  assign pay_or = pay_left_q | ({24'b0, b} << {len_idx_q, 3'b000});

  always_comb begin
    phase_d    = phase_q;
    len_left_d = len_left_q;
    len_idx_d  = len_idx_q;
    pay_left_d = pay_left_q;
    cnt_d      = cnt_q;
    bad_d      = bad_q;
    nonpush_d  = nonpush_q;
    ret_d      = ret_q;

    if (in_i.byte_present) begin
      if (cnt_q == '0 && b == OP_DATA_CARRIER) begin
        ret_d = 1'b1;
      end
      if (cnt_q != '1) begin
        cnt_d = cnt_q + 32'd1;
      end
      case (phase_q)
        PH_LENGTH: begin
          pay_left_d = pay_or;
          len_idx_d  = len_idx_q + 2'd1;
          if (len_left_q <= 3'd1) begin
            len_left_d = '0;
            if (pay_or > {16'b0, elem_limit_i}) begin
              bad_d = 1'b1;
            end
            phase_d = (pay_or != '0) ? PH_PAYLOAD : PH_OPCODE;
          end else begin
            len_left_d = len_left_q - 3'd1;
          end
        end
        PH_PAYLOAD: begin
          if (pay_left_q <= 32'd1) begin
            pay_left_d = '0;
            phase_d    = PH_OPCODE;
          end else begin
            pay_left_d = pay_left_q - 32'd1;
          end
        end
        default: begin
          phase_d = PH_OPCODE;
          if (b < OP_PUSH_LEN1) begin
            if ({8'b0, b} > elem_limit_i) begin
              bad_d = 1'b1;
            end
            pay_left_d = {24'b0, b};
            if (b != '0) begin
              phase_d = PH_PAYLOAD;
            end
          end else if (b <= OP_PUSH_LEN4) begin
            len_left_d = (b == OP_PUSH_LEN1) ? 3'd1 : (b == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
            len_idx_d  = '0;
            pay_left_d = '0;
            phase_d    = PH_LENGTH;
          end else if (b > OP_LAST_DEFINED) begin
            bad_d = 1'b1;
          end
          if (b > OP_LAST_PUSH) begin
            nonpush_d = 1'b1;
          end
        end
      endcase
    end

    // count after this byte exceeds the limit, saturation included
    if (in_i.byte_present) begin
      over = (cnt_q >= script_limit_i) && ((cnt_q != '1) || (script_limit_i != '1));
    end else begin
      over = cnt_q > script_limit_i;
    end

    well                = (phase_d != PH_LENGTH) && (phase_d != PH_PAYLOAD);
    res_o.well_formed   = well;
    res_o.valid_opcodes = well && !bad_d;
    res_o.push_only     = well && !nonpush_d;
    res_o.unspendable   = ret_d || over;

    if (in_i.last) begin
      phase_d    = PH_OPCODE;
      len_left_d = '0;
      len_idx_d  = '0;
      pay_left_d = '0;
      cnt_d      = '0;
      bad_d      = 1'b0;
      nonpush_d  = 1'b0;
      ret_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_OPCODE;
      len_left_q <= '0;
      len_idx_q  <= '0;
      pay_left_q <= '0;
      cnt_q      <= '0;
      bad_q      <= 1'b0;
      nonpush_q  <= 1'b0;
      ret_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      len_idx_q  <= len_idx_d;
      pay_left_q <= pay_left_d;
      cnt_q      <= cnt_d;
      bad_q      <= bad_d;
      nonpush_q  <= nonpush_d;
      ret_q      <= ret_d;
    end
  end

`ifndef SYNTHESIS
  a_script_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && in_i.last) |=> (phase_q == PH_OPCODE && cnt_q == '0 && !ret_q))
    else $error("parse state not cleared after end of script");

  a_len_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_LENGTH) |-> (len_left_q == '0))
    else $error("length bytes pending outside length phase");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (pay_left_q != '0))
    else $error("payload phase with nothing left");
`endif

endmodule
`default_nettype wire

// ----- hdl/script_instruction_validator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_instruction_validator_core
// Streaming script checker: one script byte per input word, four flags out.
//
// Input channel: in_valid_i / in_stall_o / in_i, one word per byte, plus an
// optional end-only word. A word with last set ends the script and yields one
// result word on out_valid_o / out_stall_i / out_o; other words yield none.
// Once its last word is accepted into the input register, the parse update
// loads the result into the result register.
// Throughput: one word per cycle unless the input side stalls.
// The input side stalls only when an ending word is held while the result
// register is full and the receiver stalls.
// Reset clears the parse state and both pipeline valids, and loads the limits
// with 520 (element) and 10000 (script). Limits are written through cfg_*;
// the user must write them only while no script is in flight, which the block
// itself does not enforce; index 0 is the element limit, 1 the script limit.
// ----------------------------------------------------------------------------
module script_instruction_validator_core
  import siv_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire in_word_t              in_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      out_word_t             out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic        in_valid_q;
  in_word_t    in_q;
  logic        out_valid_q;
  out_word_t   out_q;
  logic [15:0] elem_limit_q;
  logic [31:0] script_limit_q;
  logic        adv;
  out_word_t   res;

  assign adv        = in_valid_q && (!in_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_limit_q   <= RESET_ELEMENT_LIMIT;
      script_limit_q <= RESET_SCRIPT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ELEMENT_LIMIT: elem_limit_q   <= cfg_data_i[15:0];
        CFG_SCRIPT_LIMIT:  script_limit_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_q <= in_i;
    end
  end

  siv_parse u_parse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .in_i           (in_q),
    .elem_limit_i   (elem_limit_q),
    .script_limit_i (script_limit_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && in_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_q.last && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.last) |=> out_valid_q)
    else $error("ending word did not produce a result");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !(adv && in_q.last)) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost or overwritten");
`endif

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for script_instruction_validator_core. Scripts are fed one byte
// word at a time: a short directed set, then random well-formed scripts,
// truncated scripts and noise under several limit settings. A scoreboard
// predicts the four end-of-script flags and compares each result word.
// ----------------------------------------------------------------------------
module testbench;
  import siv_pkg::*;

  class flag_scoreboard;
    logic [15:0] element_limit;
    logic [31:0] script_limit;
    siv_phase_e  phase;
    logic [2:0]  len_left;
    logic [1:0]  len_idx;
    logic [31:0] payload_left;
    logic [31:0] byte_count;
    bit          bad_op;
    bit          non_push;
    bit          starts_ret;
    out_word_t   expected_flags[$];
    int unsigned flag_errors;

    function new();
      element_limit = RESET_ELEMENT_LIMIT;
      script_limit  = RESET_SCRIPT_LIMIT;
      flag_errors   = 0;
      clear_script();
    endfunction

    function void clear_script();
      phase        = PH_OPCODE;
      len_left     = '0;
      len_idx      = '0;
      payload_left = '0;
      byte_count   = '0;
      bad_op       = 1'b0;
      non_push     = 1'b0;
      starts_ret   = 1'b0;
    endfunction

    function void set_limits(logic [31:0] elem, logic [31:0] script);
      element_limit = elem[15:0];
      script_limit  = script;
    endfunction

    function int unsigned pending();
      return expected_flags.size();
    endfunction

    function void take_word(in_word_t w);
      logic [7:0] b;
      out_word_t  res;
      bit         well;
      b = w.data_byte;
      if (w.byte_present) begin
        if (byte_count == 0 && b == OP_DATA_CARRIER) starts_ret = 1'b1;
        if (byte_count != 32'hffff_ffff) byte_count++;
        case (phase)
          PH_LENGTH: begin
            payload_left |= {24'd0, b} << (8 * len_idx);
            len_idx++;
            if (len_left <= 1) begin
              len_left = '0;
              if (payload_left > {16'd0, element_limit}) bad_op = 1'b1;
              phase = (payload_left != 0) ? PH_PAYLOAD : PH_OPCODE;
            end else begin
              len_left--;
            end
          end
          PH_PAYLOAD: begin
            if (payload_left <= 1) begin
              payload_left = '0;
              phase = PH_OPCODE;
            end else begin
              payload_left--;
            end
          end
          default: begin
            phase = PH_OPCODE;
            if (b < OP_PUSH_LEN1) begin
              if ({8'd0, b} > element_limit) bad_op = 1'b1;
              payload_left = {24'd0, b};
              if (b != 0) phase = PH_PAYLOAD;
            end else if (b <= OP_PUSH_LEN4) begin
              len_left = (b == OP_PUSH_LEN1) ? 3'd1 : (b == OP_PUSH_LEN2) ? 3'd2 : 3'd4;
              len_idx = '0;
              payload_left = '0;
              phase = PH_LENGTH;
            end else if (b > OP_LAST_DEFINED) begin
              bad_op = 1'b1;
            end
            if (b > OP_LAST_PUSH) non_push = 1'b1;
          end
        endcase
      end
      if (w.last) begin
        well = (phase != PH_LENGTH) && (phase != PH_PAYLOAD);
        res.well_formed   = well;
        res.valid_opcodes = well && !bad_op;
        res.push_only     = well && !non_push;
        res.unspendable   = starts_ret || (byte_count > script_limit);
        expected_flags = {expected_flags, res};
        clear_script();
      end
    endfunction

    function void check_flags(out_word_t got);
      out_word_t exp_w;
      if (expected_flags.size() == 0) begin
        flag_errors++;
        if (flag_errors <= 10)
          $display("unexpected result word %b (wf vo po un)", got);
        return;
      end
      exp_w = expected_flags.pop_front();
      if (got.well_formed !== exp_w.well_formed || got.valid_opcodes !== exp_w.valid_opcodes
          || got.push_only !== exp_w.push_only || got.unspendable !== exp_w.unspendable) begin
        flag_errors++;
        if (flag_errors <= 10)
          $display("flag mismatch: expected %b got %b (wf vo po un) at %0t",
                   exp_w, got, $realtime);
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_word_t              in_i        = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_word_t             out_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_ELEMENT_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  flag_scoreboard sb = new();
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned words_sent  = 0;

  script_instruction_validator_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: per-result random stall, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 120;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_flags(out_o);
      stall_left = quiet ? 0 : $urandom_range(0, 3);
    end
  end

  initial begin
    #2_000_000;
    $display("script_instruction_validator_core regression: fail");
    $finish;
  end

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_i       <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_word(w);
    if (w.byte_present || w.last) words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit last);
    send_word(in_word_t'{data_byte: b, byte_present: 1'b1, last: last});
  endtask

  task automatic send_end();
    send_word(in_word_t'{data_byte: 8'($urandom_range(0, 255)), byte_present: 1'b0,
                         last: 1'b1});
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limits(input logic [31:0] elem, input logic [31:0] script);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ELEMENT_LIMIT;
    cfg_data_i <= {16'($urandom_range(0, 65535)), elem[15:0]};
    @(negedge clk_i);
    cfg_idx_i  <= CFG_SCRIPT_LIMIT;
    cfg_data_i <= script;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_limits(elem, script);
  endtask

  task automatic send_script(input bit cut_short);
    logic [7:0]  script_q[$];
    logic [31:0] plen;
    int unsigned n_ops;
    int unsigned n_keep;
    bit          end_marker;
    n_ops = $urandom_range(0, 5);
    if ($urandom_range(0, 7) == 0) script_q = {script_q, OP_DATA_CARRIER};
    repeat (n_ops) begin
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 75) : $urandom_range(0, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: script_q = {script_q, plen[7:0]};
        3: begin
          script_q = {script_q, OP_PUSH_LEN1};
          script_q = {script_q, plen[7:0]};
        end
        4: begin
          script_q = {script_q, OP_PUSH_LEN2};
          script_q = {script_q, plen[7:0]};
          script_q = {script_q, plen[15:8]};
        end
        5: begin
          script_q = {script_q, OP_PUSH_LEN4};
          script_q = {script_q, plen[7:0]};
          script_q = {script_q, plen[15:8]};
          script_q = {script_q, plen[23:16]};
          script_q = {script_q, plen[31:24]};
        end
        6: begin
          script_q = {script_q, 8'($urandom_range(OP_PUSH_LEN4 + 1, OP_LAST_PUSH))};
          plen = 0;
        end
        default: begin
          script_q = {script_q, 8'($urandom_range(OP_LAST_PUSH + 1, 255))};
          plen = 0;
        end
      endcase
      repeat (plen) script_q = {script_q, 8'($urandom_range(0, 255))};
    end
    if (cut_short && script_q.size() > 1) begin
      n_keep = $urandom_range(1, script_q.size() - 1);
      script_q = script_q[0:n_keep-1];
    end
    end_marker = (script_q.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (script_q[i]) begin
      if ($urandom_range(0, 15) == 0)
        send_word(in_word_t'{data_byte: 8'($urandom_range(0, 255)), byte_present: 1'b0,
                             last: 1'b0});
      send_byte(script_q[i], !end_marker && (i == script_q.size() - 1));
    end
    if (end_marker) send_end();
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n)
      send_word(in_word_t'{data_byte: 8'($urandom_range(0, 255)),
                           byte_present: ($urandom_range(0, 7) != 0),
                           last: ($urandom_range(0, 7) == 0)});
    send_end();
  endtask

  initial begin
    int unsigned target;
    int unsigned kind;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed scripts under reset limits
    send_end();
    send_byte(OP_DATA_CARRIER, 1'b1);
    send_byte(OP_LAST_DEFINED, 1'b1);
    send_byte(8'(OP_LAST_DEFINED + 1), 1'b1);
    send_byte(OP_LAST_PUSH, 1'b1);
    send_byte(8'(OP_LAST_PUSH + 1), 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(OP_PUSH_LEN1, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(OP_PUSH_LEN4, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    send_end();
    send_byte(OP_PUSH_LEN2, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'haa, 1'b0);
    send_word(in_word_t'{data_byte: 8'ha5, byte_present: 1'b0, last: 1'b0});
    send_byte(8'h55, 1'b1);
    send_byte(8'(OP_PUSH_LEN1 - 1), 1'b0);
    send_byte(8'h80, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: write_limits(32'd0, 32'd0);
        2: write_limits(32'hffff, 32'hffff_ffff);
        3: write_limits(32'd16, 32'd40);
        4: write_limits(32'd4, 32'd1);
        5: write_limits($urandom_range(0, 80), $urandom_range(0, 60));
        default: ;
      endcase
      if (p == 3) begin
        // receiver holds off while short scripts keep coming
        quiet = 1'b1;
        @(posedge clk_i);
        hold_req = 1'b1;
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      target = words_sent + 185;
      while (words_sent < target) begin
        quiet = ($urandom_range(0, 4) == 0);
        kind  = $urandom_range(0, 19);
        if (kind < 14) send_script(1'b0);
        else if (kind < 17) send_script(1'b1);
        else send_noise($urandom_range(1, 12));
      end
      quiet = 1'b0;
    end

    drain();
    if (sb.flag_errors == 0 && sb.pending() == 0) begin
      $display("script_instruction_validator_core regression: pass");
    end else begin
      $display("script_instruction_validator_core regression: fail");
    end
    $finish;
  end
endmodule
